>>> hdl/mss_pkg.sv
// Shared types, codes and reset values for the motor mode sequencer.
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

   // Field widths
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned DELAY_W = 16;
   localparam int unsigned DUR_W   = 24;
   localparam int unsigned RAMP_W  = 16;
   localparam int unsigned CSR_W   = 24;
   localparam int unsigned INDEX_W = 3;

   // Function codes of an input item
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET_MODE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP     = 2'd2;

   // Mode codes
   localparam logic [MODE_W-1:0] MODE_STOP      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FWD_AUTO  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FWD_HOLD  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FWD_STEP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REV_AUTO  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REV_HOLD  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_REV_STEP  = 3'd6;

   // Register indexes
   localparam logic [INDEX_W-1:0] CSR_START_DELAY   = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_STEP_RUN_MS   = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_AUTO_RUN_MS   = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_HOLD_DURATION = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_PWM_TARGET    = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_RAMP_INC      = 3'd5;
   localparam logic [INDEX_W-1:0] CSR_PWM_INTERVAL  = 3'd6;
   localparam logic [INDEX_W-1:0] CSR_REVERSED      = 3'd7;

   // Register reset values
   localparam logic [DELAY_W-1:0] RST_START_DELAY   = 16'd0;
   localparam logic [DUR_W-1:0]   RST_STEP_RUN_MS   = 24'd500;
   localparam logic [DUR_W-1:0]   RST_AUTO_RUN_MS   = 24'd10000;
   localparam logic [DUR_W-1:0]   RST_HOLD_DURATION = 24'd30000;
   localparam logic [LEVEL_W-1:0] RST_PWM_TARGET    = 8'd255;
   localparam logic [LEVEL_W-1:0] RST_RAMP_INC      = 8'd5;
   localparam logic [DELAY_W-1:0] RST_PWM_INTERVAL  = 16'd10;

   typedef struct packed {
      logic [DELAY_W-1:0] start_delay;
      logic [DUR_W-1:0]   step_run_ms;
      logic [DUR_W-1:0]   auto_run_ms;
      logic [DUR_W-1:0]   hold_duration;
      logic [LEVEL_W-1:0] pwm_target;
      logic [LEVEL_W-1:0] ramp_inc;
      logic [DELAY_W-1:0] pwm_interval;
      logic               reversed;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] forward_drive;
      logic [LEVEL_W-1:0] backward_drive;
      logic [MODE_W-1:0]  current_mode;
      logic               mode_changed;
   } rsp_type;

   function automatic logic is_fwd(input logic [MODE_W-1:0] m);
      return (m == MODE_FWD_AUTO) || (m == MODE_FWD_HOLD) || (m == MODE_FWD_STEP);
   endfunction

   function automatic logic is_rev(input logic [MODE_W-1:0] m);
      return (m == MODE_REV_AUTO) || (m == MODE_REV_HOLD) || (m == MODE_REV_STEP);
   endfunction

endpackage

`default_nettype wire

>>> hdl/mss_step.sv
// Next-state and result logic for one item of the motor mode sequencer.
`timescale 1ns / 1ps
`default_nettype none

module mss_step #(
   parameter int unsigned TIME_BITS = 24
) (
   input  wire logic [mss_pkg::FUNC_W-1:0]  func,
   input  wire logic [mss_pkg::MODE_W-1:0]  new_mode,
   input  wire mss_pkg::cfg_type            cfg,
   input  wire logic [mss_pkg::MODE_W-1:0]  mode,
   input  wire logic [TIME_BITS-1:0]        elapsed,
   input  wire logic [mss_pkg::RAMP_W-1:0]  ramp_timer,
   input  wire logic [mss_pkg::LEVEL_W-1:0] pwm_level,
   input  wire logic [mss_pkg::LEVEL_W-1:0] fwd_level,
   input  wire logic [mss_pkg::LEVEL_W-1:0] bwd_level,
   output logic      [mss_pkg::MODE_W-1:0]  mode_in,
   output logic      [TIME_BITS-1:0]        elapsed_in,
   output logic      [mss_pkg::RAMP_W-1:0]  ramp_timer_in,
   output logic      [mss_pkg::LEVEL_W-1:0] pwm_level_in,
   output logic      [mss_pkg::LEVEL_W-1:0] fwd_level_in,
   output logic      [mss_pkg::LEVEL_W-1:0] bwd_level_in,
   output mss_pkg::rsp_type                 rsp
);

   localparam int unsigned CMP_W = (TIME_BITS > mss_pkg::DUR_W) ? TIME_BITS : mss_pkg::DUR_W;

   logic [TIME_BITS-1:0]          el_inc;
   logic [mss_pkg::RAMP_W-1:0]    rt_inc;
   logic                          moving;
   logic                          held_off;
   logic [mss_pkg::LEVEL_W:0]     ramp_sum;
   logic [mss_pkg::LEVEL_W-1:0]   ramp_sat;
   logic [mss_pkg::LEVEL_W-1:0]   ramp_level;
   logic [mss_pkg::RAMP_W-1:0]    ramp_time;
   logic                          fwd_leg;
   logic [mss_pkg::DUR_W-1:0]     duration;
   logic                          timed_out;
   logic                          reverses;
   logic                          changed;

   // Saturating advance of both timers
   assign el_inc = (elapsed == {TIME_BITS{1'b1}}) ? elapsed : elapsed + TIME_BITS'(1);
   assign rt_inc = (ramp_timer == {mss_pkg::RAMP_W{1'b1}}) ? ramp_timer
                                                           : ramp_timer + mss_pkg::RAMP_W'(1);

   assign moving   = mss_pkg::is_fwd(mode) || mss_pkg::is_rev(mode);
   assign held_off = !moving || (el_inc < TIME_BITS'(cfg.start_delay));

   // Ramp step: saturate at full scale, then clamp to the target
   assign ramp_sum = {1'b0, pwm_level} + {1'b0, cfg.ramp_inc};
   assign ramp_sat = ramp_sum[mss_pkg::LEVEL_W] ? {mss_pkg::LEVEL_W{1'b1}}
                                                : ramp_sum[mss_pkg::LEVEL_W-1:0];
   always_comb begin
      ramp_level = pwm_level;
      ramp_time  = rt_inc;
      if (rt_inc >= cfg.pwm_interval) begin
         ramp_time = '0;
         if (pwm_level < cfg.pwm_target) begin
            ramp_level = (ramp_sat > cfg.pwm_target) ? cfg.pwm_target : ramp_sat;
         end
      end
   end

   assign fwd_leg = mss_pkg::is_fwd(mode) ^ cfg.reversed;

   // Pick the run time for the current mode kind
   always_comb begin
      case (mode)
         mss_pkg::MODE_FWD_STEP, mss_pkg::MODE_REV_STEP: duration = cfg.step_run_ms;
         mss_pkg::MODE_FWD_AUTO, mss_pkg::MODE_REV_AUTO: duration = cfg.auto_run_ms;
         default:                                        duration = cfg.hold_duration;
      endcase
   end
   assign timed_out = CMP_W'(el_inc) > CMP_W'(duration);

   assign reverses = (mode == mss_pkg::MODE_STOP)
                  || (mss_pkg::is_fwd(new_mode) && mss_pkg::is_rev(mode))
                  || (mss_pkg::is_rev(new_mode) && mss_pkg::is_fwd(mode));

   // Apply one item to the held state
   always_comb begin
      mode_in       = mode;
      elapsed_in    = elapsed;
      ramp_timer_in = ramp_timer;
      pwm_level_in  = pwm_level;
      fwd_level_in  = fwd_level;
      bwd_level_in  = bwd_level;
      changed       = 1'b0;
      case (func)
         mss_pkg::FUNC_TICK: begin
            elapsed_in = el_inc;
            if (held_off) begin
               fwd_level_in  = '0;
               bwd_level_in  = '0;
               pwm_level_in  = '0;
               ramp_timer_in = '0;
            end else begin
               pwm_level_in  = ramp_level;
               ramp_timer_in = ramp_time;
               fwd_level_in  = fwd_leg ? ramp_level : '0;
               bwd_level_in  = fwd_leg ? '0 : ramp_level;
               if (timed_out) begin
                  mode_in    = mss_pkg::MODE_STOP;
                  elapsed_in = '0;
                  changed    = 1'b1;
               end
            end
         end
         mss_pkg::FUNC_SET_MODE: begin
            if ((new_mode <= mss_pkg::MODE_REV_STEP) && (new_mode != mode)) begin
               mode_in    = new_mode;
               elapsed_in = '0;
               changed    = 1'b1;
               if (reverses) begin
                  pwm_level_in  = '0;
                  ramp_timer_in = '0;
               end
            end
         end
         mss_pkg::FUNC_STOP: begin
            changed    = (mode != mss_pkg::MODE_STOP);
            mode_in    = mss_pkg::MODE_STOP;
            elapsed_in = '0;
         end
         default: begin
            changed = 1'b0;
         end
      endcase
   end

   assign rsp.forward_drive  = fwd_level_in;
   assign rsp.backward_drive = bwd_level_in;
   assign rsp.current_mode   = mode_in;
   assign rsp.mode_changed   = changed;

endmodule

`default_nettype wire

>>> hdl/motor_mode_sequencer_soft_start.sv
// Top level of the H-bridge motor mode sequencer with soft-start ramp.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one item per transfer:
//   a one-millisecond tick, a mode command or a reset to stop.
//   Response channel (rsp_valid / rsp_stall) returns exactly one result per
//   request: both bridge leg levels, the mode now in force and a mode-change
//   flag for a beeper.
//   Results are registered in the output or, if it is full, the skid register.
//   Throughput is one item per cycle while req_stall is low; the state update
//   is a single pass of compare and add logic between the state registers.
//   An output register plus a one-entry skid register sit on the response
//   side, so req_stall comes straight from a flop and rises only when both
//   hold a result that the receiver has not yet taken.
//   The csr_ port writes the configuration registers; write only while idle.
//   Reset (synchronous) stops the motor, clears timers and ramp, loads the
//   register defaults and empties the response side.
`timescale 1ns / 1ps
`default_nettype none

module motor_mode_sequencer_soft_start #(
   parameter int unsigned TIME_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [mss_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [mss_pkg::MODE_W-1:0]    req_new_mode,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [mss_pkg::LEVEL_W-1:0]   rsp_forward_drive,
   output logic      [mss_pkg::LEVEL_W-1:0]   rsp_backward_drive,
   output logic      [mss_pkg::MODE_W-1:0]    rsp_current_mode,
   output logic                               rsp_mode_changed,
   input  wire logic                          csr_write_en,
   input  wire logic [mss_pkg::INDEX_W-1:0]   csr_index,
   input  wire logic [mss_pkg::CSR_W-1:0]     csr_data
);

   mss_pkg::cfg_type                cfg_ff;
   logic [mss_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [TIME_BITS-1:0]            elapsed_ff, elapsed_in;
   logic [mss_pkg::RAMP_W-1:0]      ramp_timer_ff, ramp_timer_in;
   logic [mss_pkg::LEVEL_W-1:0]     pwm_level_ff, pwm_level_in;
   logic [mss_pkg::LEVEL_W-1:0]     fwd_level_ff, fwd_level_in;
   logic [mss_pkg::LEVEL_W-1:0]     bwd_level_ff, bwd_level_in;
   mss_pkg::rsp_type                step_rsp;
   mss_pkg::rsp_type                out_ff;
   mss_pkg::rsp_type                skid_ff;
   logic                            out_valid_ff;
   logic                            skid_valid_ff;
   logic                            req_take;
   logic                            rsp_take;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delay   <= mss_pkg::RST_START_DELAY;
         cfg_ff.step_run_ms   <= mss_pkg::RST_STEP_RUN_MS;
         cfg_ff.auto_run_ms   <= mss_pkg::RST_AUTO_RUN_MS;
         cfg_ff.hold_duration <= mss_pkg::RST_HOLD_DURATION;
         cfg_ff.pwm_target    <= mss_pkg::RST_PWM_TARGET;
         cfg_ff.ramp_inc      <= mss_pkg::RST_RAMP_INC;
         cfg_ff.pwm_interval  <= mss_pkg::RST_PWM_INTERVAL;
         cfg_ff.reversed      <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            mss_pkg::CSR_START_DELAY:   cfg_ff.start_delay   <= csr_data[mss_pkg::DELAY_W-1:0];
            mss_pkg::CSR_STEP_RUN_MS:   cfg_ff.step_run_ms   <= csr_data[mss_pkg::DUR_W-1:0];
            mss_pkg::CSR_AUTO_RUN_MS:   cfg_ff.auto_run_ms   <= csr_data[mss_pkg::DUR_W-1:0];
            mss_pkg::CSR_HOLD_DURATION: cfg_ff.hold_duration <= csr_data[mss_pkg::DUR_W-1:0];
            mss_pkg::CSR_PWM_TARGET:    cfg_ff.pwm_target    <= csr_data[mss_pkg::LEVEL_W-1:0];
            mss_pkg::CSR_RAMP_INC:      cfg_ff.ramp_inc      <= csr_data[mss_pkg::LEVEL_W-1:0];
            mss_pkg::CSR_PWM_INTERVAL:  cfg_ff.pwm_interval  <= csr_data[mss_pkg::DELAY_W-1:0];
            mss_pkg::CSR_REVERSED:      cfg_ff.reversed      <= csr_data[0];
            default:                    cfg_ff               <= cfg_ff;
         endcase
      end
   end

   mss_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .func          (req_func),
      .new_mode      (req_new_mode),
      .cfg           (cfg_ff),
      .mode          (mode_ff),
      .elapsed       (elapsed_ff),
      .ramp_timer    (ramp_timer_ff),
      .pwm_level     (pwm_level_ff),
      .fwd_level     (fwd_level_ff),
      .bwd_level     (bwd_level_ff),
      .mode_in       (mode_in),
      .elapsed_in    (elapsed_in),
      .ramp_timer_in (ramp_timer_in),
      .pwm_level_in  (pwm_level_in),
      .fwd_level_in  (fwd_level_in),
      .bwd_level_in  (bwd_level_in),
      .rsp           (step_rsp)
   );

   // Sequencer state: advance on every request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= mss_pkg::MODE_STOP;
         elapsed_ff    <= '0;
         ramp_timer_ff <= '0;
         pwm_level_ff  <= '0;
         fwd_level_ff  <= '0;
         bwd_level_ff  <= '0;
      end else if (req_take) begin
         mode_ff       <= mode_in;
         elapsed_ff    <= elapsed_in;
         ramp_timer_ff <= ramp_timer_in;
         pwm_level_ff  <= pwm_level_in;
         fwd_level_ff  <= fwd_level_in;
         bwd_level_ff  <= bwd_level_in;
      end
   end

   // Response register with one-entry skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_ff       <= step_rsp;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= step_rsp;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_forward_drive  = out_ff.forward_drive;
   assign rsp_backward_drive = out_ff.backward_drive;
   assign rsp_current_mode   = out_ff.current_mode;
   assign rsp_mode_changed   = out_ff.mode_changed;

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_one_leg_driven: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.forward_drive == '0 || out_ff.backward_drive == '0))
      else $error("both bridge legs driven at once");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved into the output register");

   a_stop_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_func == mss_pkg::FUNC_STOP) |=> (mode_ff == mss_pkg::MODE_STOP))
      else $error("reset-to-stop command left the motor in motion");
`endif

endmodule

`default_nettype wire
